[hdl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the best path selector: candidate and
// running-best records, the per-candidate decision, and outcome codes.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned SEQ_W     = 64;
  localparam int unsigned DIGEST_W  = 64;
  localparam int unsigned HOP_BITS  = 8;
  localparam int unsigned OUTCOME_W = 2;

  // Peer id used for a path that has no peer.
  localparam logic [ID_W-1:0] NO_PEER_ID = '1;

  localparam logic [OUTCOME_W-1:0] OUTCOME_NONE     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_SELECTED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_CONFLICT = 2'd2;

  typedef struct packed {
    logic [INDEX_W-1:0]  path_index;
    logic                eligible;
    logic                from_self;
    logic                has_peer;
    logic [ID_W-1:0]     peer_node_id;
    logic [ID_W-1:0]     origin_id;
    logic [SEQ_W-1:0]    sequence_req;
    logic [DIGEST_W-1:0] payload_digest;
    logic [HOP_BITS-1:0] hop_count;
    logic                is_current;
    logic                last_path;
  } cand_t;

  typedef struct packed {
    logic                have_best;
    logic                best_rank;
    logic [SEQ_W-1:0]    best_seq;
    logic [DIGEST_W-1:0] best_digest;
    logic [INDEX_W-1:0]  best_position;
    logic [HOP_BITS-1:0] best_hops;
    logic [ID_W-1:0]     best_peer;
    logic                best_is_current;
    logic                conflict_seen;
  } best_t;

  // take_lead: new leader by rank or sequence (rank, sequence replaced,
  // conflict cleared). take_path: path fields replaced. set_conflict:
  // same rank and sequence with a different digest.
  typedef struct packed {
    logic            take_lead;
    logic            take_path;
    logic            set_conflict;
    logic            rank;
    logic [ID_W-1:0] peer;
  } decision_t;

endpackage

[hdl/best_path_selector.sv]
// ----------------------------------------------------------------------------
// best_path_selector
// Picks the best candidate path of a route entry from a stream of candidates,
// one per transaction, and reports one result per entry.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  ---------------------------------
//   in       sink       in_valid / in_stall    one candidate path
//   out      source     out_valid / out_stall  outcome, selected_index (per entry)
//   cfg      sink       cfg_wr_en              local_node_id (cfg_wr_data)
//
// One candidate per cycle sustained while in_stall is low; the compare/update
// loop on the best register sets the rate. A candidate is registered on accept
// and, if it closes the entry, its result loads into the output register when
// the staged candidate advances, which also sets out_valid.
// Reset (rst, synchronous) clears the entry state, local_node_id and both
// valid flags. in_stall rises only when the staged candidate closes an entry
// while the output register holds a stalled result.
// ----------------------------------------------------------------------------
module best_path_selector import bps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_wr_en,
  input  logic [ID_W-1:0]      cfg_wr_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [INDEX_W-1:0]   path_index,
  input  logic                 eligible,
  input  logic                 from_self,
  input  logic                 has_peer,
  input  logic [ID_W-1:0]      peer_node_id,
  input  logic [ID_W-1:0]      origin_id,
  input  logic [SEQ_W-1:0]     sequence_req,
  input  logic [DIGEST_W-1:0]  payload_digest,
  input  logic [HOP_BITS-1:0]  hop_count,
  input  logic                 is_current,
  input  logic                 last_path,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUTCOME_W-1:0] outcome,
  output logic [INDEX_W-1:0]   selected_index
);

  logic [ID_W-1:0]      local_node_id;

  // Input register stage.
  logic                 stage_valid;
  cand_t                stage;
  cand_t                cand_in;

  logic                 out_free;
  logic                 advance;
  logic                 accept;

  decision_t            decision;
  best_t                best;
  logic [OUTCOME_W-1:0] result_outcome;
  logic [INDEX_W-1:0]   result_index;

  assign cand_in = '{
    path_index:         path_index,
    eligible:           eligible,
    from_self:          from_self,
    has_peer:           has_peer,
    peer_node_id:       peer_node_id,
    origin_id:          origin_id,
    sequence_req:       sequence_req,
    payload_digest:     payload_digest,
    hop_count:          hop_count,
    is_current:         is_current,
    last_path:          last_path
  };

  // Output register can take a result if empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  // Advance the staged candidate unless it closes an entry and the result
  // has nowhere to go.
  assign advance  = stage_valid && (!stage.last_path || out_free);
  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_node_id <= '0;
    end else if (cfg_wr_en) begin
      local_node_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // Hold the payload while the stage is stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= cand_in;
    end
  end

  bps_eval u_eval (
    .cand            (stage),
    .best            (best),
    .local_node_id   (local_node_id),
    .decision        (decision)
  );

  bps_best u_best (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .cand           (stage),
    .decision       (decision),
    .best           (best),
    .result_outcome (result_outcome),
    .result_index   (result_index)
  );

  // Output register: load the entry result when the last candidate advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage.last_path) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last_path) begin
      outcome        <= result_outcome;
      selected_index <= result_index;
    end
  end

endmodule

[hdl/bps_eval.sv]
// ----------------------------------------------------------------------------
// bps_eval
// Compare one candidate against the running best and decide the update.
// ----------------------------------------------------------------------------
module bps_eval import bps_pkg::*; (
  input  cand_t            cand,
  input  best_t            best,
  input  logic [ID_W-1:0]  local_node_id,
  output decision_t        decision
);

  logic            rank;
  logic [ID_W-1:0] peer;
  logic            same_rank;
  logic            seq_greater;
  logic            seq_equal;
  logic            tie;
  logic            digest_equal;
  logic            shorter_or_lower;

  always_comb begin
    rank = !(cand.from_self ||
             (cand.has_peer && (cand.peer_node_id == cand.origin_id)));
    if (cand.from_self) begin
      peer = local_node_id;
    end else if (cand.has_peer) begin
      peer = cand.peer_node_id;
    end else begin
      peer = NO_PEER_ID;
    end

    same_rank    = (rank == best.best_rank);
    seq_greater  = (cand.sequence_req > best.best_seq);
    seq_equal    = (cand.sequence_req == best.best_seq);
    digest_equal = (cand.payload_digest == best.best_digest);
    shorter_or_lower = (cand.hop_count < best.best_hops) ||
                       ((cand.hop_count == best.best_hops) && (peer < best.best_peer));

    decision.rank = rank;
    decision.peer = peer;
    decision.take_lead = cand.eligible &&
                         (!best.have_best || (!rank && best.best_rank) ||
                          (same_rank && seq_greater));
    tie = cand.eligible && !decision.take_lead && same_rank && seq_equal;
    decision.set_conflict = tie && !digest_equal;
    decision.take_path = decision.take_lead ||
                         (tie && digest_equal &&
                          (cand.is_current || (!best.best_is_current && shorter_or_lower)));
  end

endmodule

[hdl/bps_best.sv]
// ----------------------------------------------------------------------------
// bps_best
// Running-best register of the current route entry, with the entry result.
// ----------------------------------------------------------------------------
module bps_best import bps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  cand_t                cand,
  input  decision_t            decision,
  output best_t                best,
  output logic [OUTCOME_W-1:0] result_outcome,
  output logic [INDEX_W-1:0]   result_index
);

  best_t best_next;

  always_comb begin
    best_next = best;
    if (decision.take_lead) begin
      best_next.have_best     = 1'b1;
      best_next.best_rank     = decision.rank;
      best_next.best_seq      = cand.sequence_req;
      best_next.conflict_seen = 1'b0;
    end
    if (decision.set_conflict) begin
      best_next.conflict_seen = 1'b1;
    end
    if (decision.take_path) begin
      best_next.best_position   = cand.path_index;
      best_next.best_hops       = cand.hop_count;
      best_next.best_peer       = decision.peer;
      best_next.best_digest     = cand.payload_digest;
      best_next.best_is_current = cand.is_current;
    end

    // Result of the entry as it stands after this candidate.
    if (best_next.conflict_seen) begin
      result_outcome = OUTCOME_CONFLICT;
      result_index   = '0;
    end else if (best_next.have_best) begin
      result_outcome = OUTCOME_SELECTED;
      result_index   = best_next.best_position;
    end else begin
      result_outcome = OUTCOME_NONE;
      result_index   = '0;
    end
  end

  // Drop the entry state after its last candidate.
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (advance) begin
      if (cand.last_path) begin
        best <= '0;
      end else begin
        best <= best_next;
      end
    end
  end

endmodule
